/* rtl/rau_pkg.sv */
// Shared constants, codes and state types of the rational arithmetic unit.
package rau_pkg;

    localparam int RAU_WIDTH = 32;

    localparam logic [1:0] RAU_OP_ADD = 2'd0;
    localparam logic [1:0] RAU_OP_SUB = 2'd1;
    localparam logic [1:0] RAU_OP_MUL = 2'd2;
    localparam logic [1:0] RAU_OP_DIV = 2'd3;

    localparam logic [1:0] RAU_ST_OK       = 2'd0;
    localparam logic [1:0] RAU_ST_DIVZERO  = 2'd1;
    localparam logic [1:0] RAU_ST_OVERFLOW = 2'd2;
    localparam logic [1:0] RAU_ST_ZERODEN  = 2'd3;

    typedef enum logic [2:0] {
        RAU_IDLE,
        RAU_MUL1,
        RAU_MUL2,
        RAU_MUL3,
        RAU_MUL4,
        RAU_CHECK,
        RAU_REDUCE
    } rau_state_t;

    typedef enum logic [2:0] {
        RED_IDLE,
        RED_TWOS,
        RED_GCD,
        RED_DIVN,
        RED_DIVD
    } rau_red_state_t;

endpackage

/* rtl/rational_arithmetic_unit_core.sv */
// Top level of the rational arithmetic unit: operand capture, products, sign and result.
//
// The block adds, subtracts, multiplies or divides two signed fractions and
// returns the exact result reduced to lowest terms with a positive denominator.
// An item is transferred in at a rising edge where start is high and busy is
// low; the operands are sampled from the operand ports at that edge. Unless
// the item fails early with an error, the block then keeps busy high until it
// has produced the single result of the item. The result appears on res_num,
// res_den and status for exactly one cycle, marked by done, and is transferred
// at the edge that ends that cycle. The receiver has no way to hold results
// back, and busy falls in the same cycle that done is high, so a new item may
// be started right then.
// An error (zero input denominator, divide by zero) gives done in the cycle
// after the transfer. Otherwise the steps MUL1 to MUL3, plus MUL4 for a sum or
// difference, use the single WIDTH x WIDTH multiplier; a zero check follows,
// and then the reduction engine strips common factors of two, runs a
// data-dependent binary gcd and divides numerator and denominator by the gcd
// with restoring division. A zero result skips the reduction.
// Reset clears the sequencer and the done strobe; no result is pending after it.
module rational_arithmetic_unit_core
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [1:0]  operation,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    output logic [31:0] res_num,
    output logic [30:0] res_den,
    output logic [1:0]  status
);

    localparam int N = 2 * WIDTH;
    localparam logic [N-1:0] HALF = N'(1) << (WIDTH - 1);

    rau_state_t     state_reg, state_next;
    logic [1:0]     op_reg, op_next;
    logic [WIDTH-1:0] an_reg, an_next;
    logic [WIDTH-1:0] ad_reg, ad_next;
    logic [WIDTH-1:0] bn_reg, bn_next;
    logic [WIDTH-1:0] bd_reg, bd_next;
    logic           sa_reg, sa_next;
    logic           sb_reg, sb_next;
    logic           bnz_reg, bnz_next;
    logic [N-1:0]   x_reg, x_next;
    logic [N-1:0]   y_reg, y_next;
    logic [N-1:0]   p_reg, p_next;
    logic           neg_reg, neg_next;
    logic           negpend_reg, negpend_next;
    logic [31:0]    res_num_reg, res_num_next;
    logic [30:0]    res_den_reg, res_den_next;
    logic [1:0]     status_reg, status_next;
    logic           done_reg, done_next;

    // Sign and magnitude of each operand, taken from the low WIDTH bits.
    logic [WIDTH-1:0] an_bits, ad_bits, bn_bits, bd_bits;
    logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;

    assign an_bits = a_num[WIDTH-1:0];
    assign ad_bits = a_den[WIDTH-1:0];
    assign bn_bits = b_num[WIDTH-1:0];
    assign bd_bits = b_den[WIDTH-1:0];
    assign an_mag  = an_bits[WIDTH-1] ? (~an_bits + 1'b1) : an_bits;
    assign ad_mag  = ad_bits[WIDTH-1] ? (~ad_bits + 1'b1) : ad_bits;
    assign bn_mag  = bn_bits[WIDTH-1] ? (~bn_bits + 1'b1) : bn_bits;
    assign bd_mag  = bd_bits[WIDTH-1] ? (~bd_bits + 1'b1) : bd_bits;

    // The one multiplier; its operands are chosen by the sequencer step.
    logic [WIDTH-1:0] mul_a, mul_b;
    logic             is_mul, is_div, is_addsub;

    assign is_mul    = (op_reg == RAU_OP_MUL);
    assign is_div    = (op_reg == RAU_OP_DIV);
    assign is_addsub = !is_mul && !is_div;

    always_comb
    begin
        case (state_reg)
            RAU_MUL1:
            begin
                mul_a = an_reg;
                mul_b = is_mul ? bn_reg : bd_reg;
            end
            RAU_MUL2:
            begin
                if (is_mul)
                begin
                    mul_a = ad_reg;
                    mul_b = bd_reg;
                end
                else if (is_div)
                begin
                    mul_a = ad_reg;
                    mul_b = bn_reg;
                end
                else
                begin
                    mul_a = bn_reg;
                    mul_b = ad_reg;
                end
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    // Sum or difference of the two cross products. The sign of the second
    // term is the sign of b, flipped for a subtract, and never negative for
    // a zero term.
    logic         s2;
    logic         eff_sub;
    logic [N:0]   add_b;
    logic [N:0]   add_res;

    assign s2      = bnz_reg ? 1'b0 : ((op_reg == RAU_OP_SUB) ? !sb_reg : sb_reg);
    assign eff_sub = (sa_reg != s2);
    assign add_b   = eff_sub ? ~{1'b0, p_reg} : {1'b0, p_reg};
    assign add_res = {1'b0, x_reg} + add_b + (N + 1)'(eff_sub);

    // Reduction engine.
    logic         red_start;
    logic         red_done;
    logic [N-1:0] red_num;
    logic [N-1:0] red_den;

    rau_reduce #(
        .WIDTH (WIDTH)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .num     (x_reg),
        .den     (y_reg),
        .done    (red_done),
        .red_num (red_num),
        .red_den (red_den)
    );

    // Range check and two's complement form of a reduced result.
    logic             ovf;
    logic [WIDTH-1:0] num_w;

    assign ovf   = (red_den >= HALF) || (neg_reg ? (red_num > HALF) : (red_num >= HALF));
    assign num_w = neg_reg ? (~red_num[WIDTH-1:0] + 1'b1) : red_num[WIDTH-1:0];

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        bnz_next     = bnz_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        p_next       = N'(mul_a) * N'(mul_b);
        neg_next     = neg_reg;
        negpend_next = negpend_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        status_next  = status_reg;
        done_next    = 1'b0;
        red_start    = 1'b0;
        case (state_reg)
            RAU_IDLE:
            begin
                if (start)
                begin
                    op_next  = operation;
                    an_next  = an_mag;
                    ad_next  = ad_mag;
                    bn_next  = bn_mag;
                    bd_next  = bd_mag;
                    sa_next  = (an_bits[WIDTH-1] != ad_bits[WIDTH-1]) && (an_mag != '0);
                    sb_next  = (bn_bits[WIDTH-1] != bd_bits[WIDTH-1]) && (bn_mag != '0);
                    bnz_next = (bn_mag == '0);
                    if (ad_mag == '0 || bd_mag == '0)
                    begin
                        res_num_next = '0;
                        res_den_next = 31'd1;
                        status_next  = RAU_ST_ZERODEN;
                        done_next    = 1'b1;
                    end
                    else if (operation == RAU_OP_DIV && bn_mag == '0)
                    begin
                        res_num_next = '0;
                        res_den_next = 31'd1;
                        status_next  = RAU_ST_DIVZERO;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = RAU_MUL1;
                    end
                end
            end
            RAU_MUL1:
            begin
                state_next = RAU_MUL2;
            end
            RAU_MUL2:
            begin
                x_next     = p_reg;
                state_next = RAU_MUL3;
            end
            RAU_MUL3:
            begin
                if (is_addsub)
                begin
                    // A borrow out means the second term was the larger one.
                    x_next       = add_res[N-1:0];
                    negpend_next = eff_sub && add_res[N];
                    neg_next     = (eff_sub && add_res[N]) ? s2 : sa_reg;
                    state_next   = RAU_MUL4;
                end
                else
                begin
                    y_next     = p_reg;
                    neg_next   = sa_reg != sb_reg;
                    state_next = RAU_CHECK;
                end
            end
            RAU_MUL4:
            begin
                y_next = p_reg;
                if (negpend_reg)
                begin
                    x_next = N'(0) - x_reg;
                end
                state_next = RAU_CHECK;
            end
            RAU_CHECK:
            begin
                if (x_reg == '0)
                begin
                    res_num_next = '0;
                    res_den_next = 31'd1;
                    status_next  = RAU_ST_OK;
                    done_next    = 1'b1;
                    state_next   = RAU_IDLE;
                end
                else
                begin
                    red_start  = 1'b1;
                    state_next = RAU_REDUCE;
                end
            end
            RAU_REDUCE:
            begin
                if (red_done)
                begin
                    if (ovf)
                    begin
                        res_num_next = '0;
                        res_den_next = 31'd1;
                        status_next  = RAU_ST_OVERFLOW;
                    end
                    else
                    begin
                        res_num_next = 32'($signed(num_w));
                        res_den_next = 31'(red_den[WIDTH-2:0]);
                        status_next  = RAU_ST_OK;
                    end
                    done_next  = 1'b1;
                    state_next = RAU_IDLE;
                end
            end
            default:
            begin
                state_next = RAU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RAU_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        bnz_reg     <= bnz_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        p_reg       <= p_next;
        neg_reg     <= neg_next;
        negpend_reg <= negpend_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        status_reg  <= status_next;
    end

    assign busy    = (state_reg != RAU_IDLE);
    assign done    = done_reg;
    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

endmodule

/* rtl/rau_reduce.sv */
// Fraction reduction engine: binary gcd and restoring division on one shared subtractor.
module rau_reduce
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2*WIDTH-1:0]     num,
    input  logic [2*WIDTH-1:0]     den,
    output logic                   done,
    output logic [2*WIDTH-1:0]     red_num,
    output logic [2*WIDTH-1:0]     red_den
);

    localparam int N  = 2 * WIDTH;
    localparam int CW = $clog2(N);

    rau_red_state_t state_reg, state_next;
    logic [N-1:0]   n_reg, n_next;
    logic [N-1:0]   d_reg, d_next;
    logic [N-1:0]   u_reg, u_next;
    logic [N-1:0]   v_reg, v_next;
    logic [N-1:0]   rem_reg, rem_next;
    logic [N-1:0]   q_reg, q_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;

    logic [N:0]     rem_sh;
    logic [N:0]     sub_a;
    logic [N-1:0]   sub_b;
    logic [N+1:0]   diff;
    logic           borrow;
    logic [N-1:0]   q_step;
    logic [N-1:0]   rem_step;
    logic           last;

    // The gcd compares u against v; the division compares the shifted
    // remainder against the gcd, which is left in u.
    assign rem_sh   = {rem_reg, q_reg[N-1]};
    assign sub_a    = (state_reg == RED_GCD) ? {1'b0, u_reg} : rem_sh;
    assign sub_b    = (state_reg == RED_GCD) ? v_reg : u_reg;
    assign diff     = {1'b0, sub_a} - {2'b00, sub_b};
    assign borrow   = diff[N+1];
    assign q_step   = {q_reg[N-2:0], ~borrow};
    assign rem_step = borrow ? rem_sh[N-1:0] : diff[N-1:0];
    assign last     = (cnt_reg == CW'(N - 1));

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            RED_IDLE:
            begin
                if (start)
                begin
                    n_next     = num;
                    d_next     = den;
                    state_next = RED_TWOS;
                end
            end
            RED_TWOS:
            begin
                // Common factors of two come straight off the results.
                if (!n_reg[0] && !d_reg[0])
                begin
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end
                else
                begin
                    u_next     = n_reg;
                    v_next     = d_reg;
                    state_next = RED_GCD;
                end
            end
            RED_GCD:
            begin
                if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (diff == '0)
                begin
                    q_next     = n_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = RED_DIVN;
                end
                else if (!borrow)
                begin
                    u_next = diff[N-1:0];
                end
                else
                begin
                    u_next = v_reg;
                    v_next = u_reg;
                end
            end
            RED_DIVN:
            begin
                if (last)
                begin
                    n_next     = q_step;
                    q_next     = d_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = RED_DIVD;
                end
                else
                begin
                    q_next   = q_step;
                    rem_next = rem_step;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            RED_DIVD:
            begin
                q_next   = q_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    d_next     = q_step;
                    done_next  = 1'b1;
                    state_next = RED_IDLE;
                end
            end
            default:
            begin
                state_next = RED_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RED_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done    = done_reg;
    assign red_num = n_reg;
    assign red_den = d_reg;

endmodule

/* sim/rational_arithmetic_unit_checker.sv */
// Checker for the rational arithmetic unit: predicts each reduced fraction and compares results.
`timescale 1ns / 100ps

module rational_arithmetic_unit_checker
    import rau_pkg::*;
#(
    parameter int WIDTH = RAU_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [1:0]  operation,
    input  logic [31:0] a_num,
    input  logic [31:0] a_den,
    input  logic [31:0] b_num,
    input  logic [31:0] b_den,
    input  logic [31:0] res_num,
    input  logic [30:0] res_den,
    input  logic [1:0]  status,
    output int          failures,
    output int          pending
);

    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  st;
    } fraction_result_t;

    fraction_result_t expected_fractions[$];
    int fail_total = 0;
    int open_count = 0;

    assign failures = fail_total;
    assign pending  = open_count;

    // Operands live in the low WIDTH bits as two's complement.
    function automatic void split_operand(input logic [31:0] raw, output logic neg,
                                          output logic [63:0] mag);
        logic [63:0] full;
        logic [63:0] bits_v;
        full   = 64'd1 << WIDTH;
        bits_v = {32'd0, raw} & (full - 64'd1);
        neg    = bits_v[WIDTH-1];
        mag    = neg ? full - bits_v : bits_v;
    endfunction

    function automatic fraction_result_t reduce_rational_op(input logic [1:0] op,
                                                            input logic [31:0] an_raw,
                                                            input logic [31:0] ad_raw,
                                                            input logic [31:0] bn_raw,
                                                            input logic [31:0] bd_raw);
        fraction_result_t r;
        logic        an_neg, ad_neg, bn_neg, bd_neg;
        logic [63:0] an, ad, bn, bd;
        logic [63:0] t1, t2, rmag, rden, x, y, rem, half;
        logic        sa, sb, s2, rneg;
        logic [31:0] mag32;

        half  = 64'd1 << (WIDTH - 1);
        r.num = '0;
        r.den = 31'd1;
        split_operand(an_raw, an_neg, an);
        split_operand(ad_raw, ad_neg, ad);
        split_operand(bn_raw, bn_neg, bn);
        split_operand(bd_raw, bd_neg, bd);

        if (ad == 0 || bd == 0) begin
            r.st = RAU_ST_ZERODEN;
            return r;
        end
        if (op == RAU_OP_DIV && bn == 0) begin
            r.st = RAU_ST_DIVZERO;
            return r;
        end

        sa = (an_neg != ad_neg) && an != 0;
        sb = (bn_neg != bd_neg) && bn != 0;

        if (op == RAU_OP_MUL) begin
            rneg = sa != sb;
            rmag = an * bn;
            rden = ad * bd;
        end
        else if (op == RAU_OP_DIV) begin
            rneg = sa != sb;
            rmag = an * bd;
            rden = ad * bn;
        end
        else begin
            t1 = an * bd;
            t2 = bn * ad;
            s2 = (op == RAU_OP_SUB) ? !sb : sb;
            if (t2 == 0)
                s2 = 1'b0;
            if (sa == s2) begin
                rneg = sa;
                rmag = t1 + t2;
            end
            else if (t1 >= t2) begin
                rneg = sa;
                rmag = t1 - t2;
            end
            else begin
                rneg = s2;
                rmag = t2 - t1;
            end
            rden = ad * bd;
        end

        // Euclid on the exact magnitudes; the denominator is never zero here.
        x = rmag;
        y = rden;
        while (y != 0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        rmag = rmag / x;
        rden = rden / x;
        if (rmag == 0) begin
            rneg = 1'b0;
            rden = 64'd1;
        end

        if (rden > half - 1 || (rneg ? rmag > half : rmag > half - 1)) begin
            r.st = RAU_ST_OVERFLOW;
            return r;
        end
        mag32 = rmag[31:0];
        r.num = rneg ? -mag32 : mag32;
        r.den = rden[30:0];
        r.st  = RAU_ST_OK;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        fraction_result_t want;
        int bad;
        if (rst_n) begin
            bad = 0;
            // A result leaves before a new item enters at the same edge.
            if (done) begin
                if (expected_fractions.size() == 0) begin
                    $error("result %0d/%0d status %0d with no item outstanding",
                           $signed(res_num), res_den, status);
                    bad++;
                end
                else begin
                    want = expected_fractions.pop_front();
                    if (res_num !== want.num) begin
                        $error("res_num: expected %0d, got %0d",
                               $signed(want.num), $signed(res_num));
                        bad++;
                    end
                    if (res_den !== want.den) begin
                        $error("res_den: expected %0d, got %0d", want.den, res_den);
                        bad++;
                    end
                    if (status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        bad++;
                    end
                end
            end
            if (start && !busy)
                expected_fractions.push_back(
                    reduce_rational_op(operation, a_num, a_den, b_num, b_den));
            fail_total <= fail_total + bad;
            open_count <= expected_fractions.size();
        end
    end

endmodule

/* sim/rational_arithmetic_unit_core_test.sv */
// Testbench top for the rational arithmetic unit: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps

module rational_arithmetic_unit_core_test
    import rau_pkg::*;
();

    // Handy operand values at the edges of the 32-bit range.
    localparam logic [31:0] MAX_POS   = 32'h7fff_ffff;
    localparam logic [31:0] MIN_NEG   = 32'h8000_0000;
    localparam logic [31:0] MINUS_ONE = 32'hffff_ffff;

    // Number of random items after the directed part.
    localparam int RANDOM_ITEMS = 1530;
    // The settle and drain waits are sized from the worst case per item.
    localparam int SETTLE_CYCLES = 500;
    localparam int DRAIN_LIMIT   = 20000;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic [1:0]  operation = RAU_OP_ADD;
    logic [31:0] a_num     = '0;
    logic [31:0] a_den     = 32'd1;
    logic [31:0] b_num     = '0;
    logic [31:0] b_den     = 32'd1;
    logic        busy;
    logic        done;
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;

    int failures;
    int pending;

    // Percentage of cycles in which the sender holds back a new item.
    int idle_pct = 37;

    rational_arithmetic_unit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

    // The checker sees the same ports as the block and keeps its own prediction.
    rational_arithmetic_unit_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .operation (operation),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs. About 1550 items at the worst-case
    // latency plus sender gaps come to roughly 9 ms, so this leaves a wide margin.
    initial
    begin
        #40_000_000;
        $display("[rational_arithmetic_unit_core] ERROR");
        $finish;
    end

    // One transfer: the sender may first idle for a few cycles, with junk on the
    // operand ports, then holds start high until the block takes the item. Start
    // stays high while the block is busy, so a waiting item goes in the very cycle
    // that busy falls. Each call makes at most one assignment to start per edge.
    task automatic transfer_item(input logic [1:0] op, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start     <= 1'b0;
            operation <= 2'($urandom);
            a_num     <= $urandom;
            a_den     <= $urandom;
            b_num     <= $urandom;
            b_den     <= $urandom;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        a_num     <= an;
        a_den     <= ad;
        b_num     <= bn;
        b_den     <= bd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Operand mix: small values (45 percent of picks), which keep results in
    // range and exercise the gcd, plus values rich in factors of two, edge values
    // and full-range noise, which drives the overflow path.
    function automatic logic [31:0] random_operand();
        int unsigned pick;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            v = 32'(int'($urandom_range(0, 128)) - 64);
        else if (pick < 45)
            v = 32'(int'($urandom_range(0, 131070)) - 65535);
        else if (pick < 65)
        begin
            v = 32'($urandom_range(1, 1000)) << $urandom_range(0, 20);
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 5))
                0: v = '0;
                1: v = 32'd1;
                2: v = MINUS_ONE;
                3: v = MAX_POS;
                4: v = MIN_NEG;
                default: v = MIN_NEG + 32'd1;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    // Denominators are nonzero in all but a few percent of items, so most items
    // reach the multiplier and the reduction instead of failing early.
    function automatic logic [31:0] random_denominator();
        logic [31:0] v;
        if ($urandom_range(0, 99) < 3)
            return '0;
        v = random_operand();
        if (v == 0)
            v = 32'd1;
        return v;
    endfunction

    initial
    begin : stimulus
        int waited;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Plain cases first: a sum with reduction, an exact zero
        // result, and a product of two fractions with negative parts.
        transfer_item(RAU_OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        transfer_item(RAU_OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        transfer_item(RAU_OP_MUL, -32'sd2, 32'd3, 32'd3, -32'sd4);
        // A divide by a zero fraction, then each zero denominator. The zero
        // denominator check wins over the divide by zero.
        transfer_item(RAU_OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
        transfer_item(RAU_OP_ADD, 32'd7, 32'd0, 32'd1, 32'd3);
        transfer_item(RAU_OP_SUB, 32'd7, 32'd5, 32'd1, 32'd0);
        transfer_item(RAU_OP_DIV, 32'd7, 32'd0, 32'd0, 32'd0);
        // Results at and just past the numerator range.
        transfer_item(RAU_OP_MUL, MAX_POS, 32'd1, MAX_POS, 32'd1);
        transfer_item(RAU_OP_MUL, MIN_NEG, 32'd1, 32'd1, 32'd1);
        transfer_item(RAU_OP_MUL, MIN_NEG, 32'd1, MINUS_ONE, 32'd1);
        transfer_item(RAU_OP_DIV, MIN_NEG, MINUS_ONE, 32'd1, 32'd1);
        transfer_item(RAU_OP_ADD, MAX_POS, 32'd1, MAX_POS, 32'd1);
        transfer_item(RAU_OP_SUB, MIN_NEG, 32'd1, MAX_POS, 32'd1);
        // Denominators at and past the top of their range.
        transfer_item(RAU_OP_ADD, 32'd1, MAX_POS, 32'd1, MAX_POS);
        transfer_item(RAU_OP_MUL, 32'd1, MAX_POS, 32'd1, 32'd2);
        transfer_item(RAU_OP_DIV, 32'd1, 32'd1, 32'd1, MIN_NEG);
        // Signs carried by denominators, zero numerators and mixed sums.
        transfer_item(RAU_OP_SUB, MINUS_ONE, MINUS_ONE, MINUS_ONE, 32'd1);
        transfer_item(RAU_OP_DIV, 32'd0, 32'd7, 32'd3, 32'd5);
        transfer_item(RAU_OP_MUL, 32'd0, -32'sd3, MIN_NEG, MIN_NEG);
        transfer_item(RAU_OP_ADD, 32'd6, -32'sd4, 32'd3, 32'd8);
        transfer_item(RAU_OP_DIV, MIN_NEG, MAX_POS, MAX_POS, MIN_NEG);
        transfer_item(RAU_OP_ADD, 32'd12, 32'd18, 32'd0, -32'sd7);

        // Random part. A stretch in the middle runs back to back with no sender
        // gaps, so items start in the cycle the previous result leaves.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = (i >= 500 && i < 800) ? 0 : 37;
            transfer_item(2'($urandom_range(0, 3)), random_operand(), random_denominator(),
                          random_operand(), random_denominator());
        end
        start <= 1'b0;
        // Give the checker one edge to count the last item as outstanding.
        @(posedge clk);

        // Wait for the last result, then let the block settle so that a stray
        // extra result would still be caught.
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending != 0)
        begin
            $display("[rational_arithmetic_unit_core] ERROR");
        end
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (failures == 0 && pending == 0)
                $display("[rational_arithmetic_unit_core] OK");
            else
                $display("[rational_arithmetic_unit_core] ERROR");
        end
        $finish;
    end

endmodule
